// ===== src/ssa_pkg.sv =====
// Shared types and constants for the sample statistics aggregator.
`default_nettype none
package ssa_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned MEAN_W   = 24;

  // Result status codes.
  typedef enum logic [1:0] {
    STS_STORED = 2'd0,
    STS_FULL   = 2'd1,
    STS_VALID  = 2'd2,
    STS_EMPTY  = 2'd3
  } status_e;

  // Input action codes.
  typedef enum logic {
    ACT_PUSH      = 1'b0,
    ACT_AGGREGATE = 1'b1
  } action_e;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_PUSH,
    OP_EMPTY,
    OP_SUM_START,
    OP_SCAN,
    OP_DIV_START,
    OP_DIV,
    OP_SEL_RD,
    OP_SEL_CAP,
    OP_SEL_NEXT,
    OP_FINISH
  } op_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_SEL_RD,
    ST_SEL_CAP,
    ST_SEL_SCAN
  } state_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic scan_done;
    logic div_done;
    logic found;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== src/ssa_in_if.sv =====
// Input channel: one push or aggregate request per beat.
`default_nettype none
interface ssa_in_if;
  logic                valid;
  logic                ready;
  logic                action;
  logic signed [15:0]  sample_value;

  modport source (output valid, action, sample_value, input ready);
  modport sink   (input valid, action, sample_value, output ready);
endinterface
`default_nettype wire

// ===== src/ssa_out_if.sv =====
// Output channel: one result per beat.
`default_nettype none
interface ssa_out_if;
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic signed [15:0]  minimum;
  logic signed [15:0]  maximum;
  logic signed [23:0]  mean_q8;
  logic signed [15:0]  median;
  logic [6:0]          sample_total;

  modport source (output valid, status, minimum, maximum, mean_q8, median, sample_total,
                  input ready);
  modport sink   (input valid, status, minimum, maximum, mean_q8, median, sample_total,
                  output ready);
endinterface
`default_nettype wire

// ===== src/sample_statistics_aggregator.sv =====
// Sample statistics aggregator: a push's result is registered. An aggregate
// over n held samples is accepted, then makes a min/max/sum pass over the
// single-port store, then a bit-serial restoring division with a
// 16 + 8 + clog2(SampleDepth + 1)-bit quotient for the mean, then finds the
// median, trying stored samples in order as candidates and counting, with
// one store read per cycle, how many samples lie below and at each candidate.
// Input is not accepted while an aggregate runs.
`default_nettype none
module sample_statistics_aggregator #(
  parameter int unsigned SAMPLE_DEPTH = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ssa_in_if.sink    sample_i,
  ssa_out_if.source stats_o
);
  import ssa_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t dp_status;

  ssa_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_action_i (sample_i.action),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (stats_o.valid),
    .out_ready_i (stats_o.ready),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  ssa_datapath #(
    .SampleDepth (SAMPLE_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (dp_status),
    .sample_i     (sample_i.sample_value),
    .res_status_o (stats_o.status),
    .res_min_o    (stats_o.minimum),
    .res_max_o    (stats_o.maximum),
    .res_mean_o   (stats_o.mean_q8),
    .res_median_o (stats_o.median),
    .res_total_o  (stats_o.sample_total)
  );

endmodule
`default_nettype wire

// ===== src/ssa_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none
module ssa_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write or read one word per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule
`default_nettype wire

// ===== src/ssa_datapath.sv =====
// Datapath: sample store, count, scan unit, divider and median selection.
`default_nettype none
module ssa_datapath #(
  parameter int unsigned SampleDepth = 64
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire ssa_pkg::dp_cmd_t          cmd_i,
  output ssa_pkg::dp_status_t            status_o,
  input  wire logic signed [15:0]        sample_i,
  output logic [1:0]                     res_status_o,
  output logic signed [15:0]             res_min_o,
  output logic signed [15:0]             res_max_o,
  output logic signed [23:0]             res_mean_o,
  output logic signed [15:0]             res_median_o,
  output logic [6:0]                     res_total_o
);
  import ssa_pkg::*;

  localparam int unsigned AW  = (SampleDepth > 1) ? $clog2(SampleDepth) : 1;
  localparam int unsigned CW  = $clog2(SampleDepth + 1);
  localparam int unsigned SW  = SAMPLE_W + CW;
  localparam int unsigned DW  = SW + 8;
  localparam int unsigned DCW = $clog2(DW + 1);

  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          ra_q, ra_d;
  logic                   rv_q, rv_d;
  logic                   sel_mode_q, sel_mode_d;
  logic signed [15:0]     min_q, min_d, max_q, max_d, cand_q, cand_d;
  logic signed [SW-1:0]   sum_q, sum_d;
  logic [CW-1:0]          lt_q, lt_d, le_q, le_d, c_q, c_d;
  logic [DW-1:0]          dq_q, dq_d;
  logic [CW:0]            rem_q, rem_d;
  logic [DCW-1:0]         dcnt_q, dcnt_d;
  logic                   neg_q, neg_d;

  logic                   ram_we;
  logic [AW-1:0]          ram_addr;
  logic [15:0]            ram_rdata;
  logic signed [15:0]     rd_val;
  logic                   full;
  logic [CW-1:0]          half;
  logic [CW:0]            rem_sh;
  logic signed [DW-1:0]   sum_ext;
  logic [DW-1:0]          mean_mag;

  logic [1:0]             r_sts_d;
  logic signed [15:0]     r_min_d, r_max_d, r_med_d;
  logic signed [23:0]     r_mean_d;
  logic [6:0]             r_tot_d;

  assign rd_val   = $signed(ram_rdata);
  assign full     = (count_q == CW'(SampleDepth));
  assign half     = count_q >> 1;
  assign rem_sh   = {rem_q[CW-1:0], dq_q[DW-1]};
  assign sum_ext  = {sum_q, 8'd0};
  assign mean_mag = neg_q ? (~dq_q + DW'(1)) : dq_q;

  assign status_o.empty     = (count_q == '0);
  assign status_o.scan_done = (ra_q >= count_q) && !rv_q;
  assign status_o.div_done  = (dcnt_q == '0);
  assign status_o.found     = (lt_q <= half) && (le_q > half);

  // Store port: push writes at the count, selection reads the candidate, scans read at ra_q.
  always_comb begin
    ram_we   = (cmd_i.op == OP_PUSH) && !full;
    ram_addr = ra_q[AW-1:0];
    if (cmd_i.op == OP_PUSH) begin
      ram_addr = count_q[AW-1:0];
    end else if (cmd_i.op == OP_SEL_RD) begin
      ram_addr = c_q[AW-1:0];
    end
  end

  ssa_ram #(
    .Width (SAMPLE_W),
    .Depth (SampleDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (sample_i),
    .rdata_o (ram_rdata)
  );

  // Next-state logic for all datapath registers.
  always_comb begin
    count_d    = count_q;
    ra_d       = ra_q;
    rv_d       = rv_q;
    sel_mode_d = sel_mode_q;
    min_d      = min_q;
    max_d      = max_q;
    cand_d     = cand_q;
    sum_d      = sum_q;
    lt_d       = lt_q;
    le_d       = le_q;
    c_d        = c_q;
    dq_d       = dq_q;
    rem_d      = rem_q;
    dcnt_d     = dcnt_q;
    neg_d      = neg_q;
    r_sts_d    = res_status_o;
    r_min_d    = res_min_o;
    r_max_d    = res_max_o;
    r_mean_d   = res_mean_o;
    r_med_d    = res_median_o;
    r_tot_d    = res_total_o;
    case (cmd_i.op)
      OP_PUSH: begin
        if (!full) begin
          count_d = count_q + CW'(1);
          r_sts_d = STS_STORED;
          r_tot_d = 7'(count_q + CW'(1));
        end else begin
          r_sts_d = STS_FULL;
          r_tot_d = 7'(count_q);
        end
        r_min_d  = '0;
        r_max_d  = '0;
        r_mean_d = '0;
        r_med_d  = '0;
      end
      OP_EMPTY: begin
        r_sts_d  = STS_EMPTY;
        r_tot_d  = '0;
        r_min_d  = '0;
        r_max_d  = '0;
        r_mean_d = '0;
        r_med_d  = '0;
      end
      OP_SUM_START: begin
        ra_d       = '0;
        rv_d       = 1'b0;
        sel_mode_d = 1'b0;
        min_d      = 16'sh7fff;
        max_d      = -16'sh8000;
        sum_d      = '0;
      end
      OP_SCAN: begin
        // Issue the next read and fold in the word that arrives this cycle.
        rv_d = (ra_q < count_q);
        if (ra_q < count_q) begin
          ra_d = ra_q + CW'(1);
        end
        if (rv_q) begin
          if (sel_mode_q) begin
            if (rd_val < cand_q) lt_d = lt_q + CW'(1);
            if (rd_val <= cand_q) le_d = le_q + CW'(1);
          end else begin
            sum_d = sum_q + SW'(rd_val);
            if (rd_val < min_q) min_d = rd_val;
            if (rd_val > max_q) max_d = rd_val;
          end
        end
      end
      OP_DIV_START: begin
        neg_d  = sum_q[SW-1];
        dq_d   = sum_q[SW-1] ? (~sum_ext + DW'(1)) : sum_ext;
        rem_d  = '0;
        dcnt_d = DCW'(DW);
        c_d    = '0;
      end
      OP_DIV: begin
        // One restoring division step per cycle.
        if (rem_sh >= {1'b0, count_q}) begin
          rem_d = rem_sh - {1'b0, count_q};
          dq_d  = {dq_q[DW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          dq_d  = {dq_q[DW-2:0], 1'b0};
        end
        dcnt_d = dcnt_q - DCW'(1);
      end
      OP_SEL_CAP: begin
        cand_d     = rd_val;
        ra_d       = '0;
        rv_d       = 1'b0;
        lt_d       = '0;
        le_d       = '0;
        sel_mode_d = 1'b1;
      end
      OP_SEL_NEXT: begin
        c_d = c_q + CW'(1);
      end
      OP_FINISH: begin
        r_sts_d  = STS_VALID;
        r_min_d  = min_q;
        r_max_d  = max_q;
        r_mean_d = mean_mag[MEAN_W-1:0];
        r_med_d  = cand_q;
        r_tot_d  = 7'(count_q);
        count_d  = '0;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      ra_q       <= '0;
      rv_q       <= 1'b0;
      sel_mode_q <= 1'b0;
      dcnt_q     <= '0;
      c_q        <= '0;
    end else begin
      count_q    <= count_d;
      ra_q       <= ra_d;
      rv_q       <= rv_d;
      sel_mode_q <= sel_mode_d;
      dcnt_q     <= dcnt_d;
      c_q        <= c_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    min_q        <= min_d;
    max_q        <= max_d;
    cand_q       <= cand_d;
    sum_q        <= sum_d;
    lt_q         <= lt_d;
    le_q         <= le_d;
    dq_q         <= dq_d;
    rem_q        <= rem_d;
    neg_q        <= neg_d;
    res_status_o <= r_sts_d;
    res_min_o    <= r_min_d;
    res_max_o    <= r_max_d;
    res_mean_o   <= r_mean_d;
    res_median_o <= r_med_d;
    res_total_o  <= r_tot_d;
  end

endmodule
`default_nettype wire

// ===== src/ssa_controller.sv =====
// Controller: sequences pushes and the aggregation passes.
`default_nettype none
module ssa_controller (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_action_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  input  wire ssa_pkg::dp_status_t status_i,
  output ssa_pkg::dp_cmd_t         cmd_o
);
  import ssa_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  // State register and output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath command.
  always_comb begin
    state_d     = state_q;
    cmd_o.op    = OP_NONE;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          if (in_action_i == ACT_PUSH) begin
            cmd_o.op    = OP_PUSH;
            out_valid_d = 1'b1;
          end else if (status_i.empty) begin
            cmd_o.op    = OP_EMPTY;
            out_valid_d = 1'b1;
          end else begin
            cmd_o.op = OP_SUM_START;
            state_d  = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        if (status_i.scan_done) begin
          cmd_o.op = OP_DIV_START;
          state_d  = ST_DIV;
        end else begin
          cmd_o.op = OP_SCAN;
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_SEL_RD;
        end else begin
          cmd_o.op = OP_DIV;
        end
      end
      ST_SEL_RD: begin
        cmd_o.op = OP_SEL_RD;
        state_d  = ST_SEL_CAP;
      end
      ST_SEL_CAP: begin
        cmd_o.op = OP_SEL_CAP;
        state_d  = ST_SEL_SCAN;
      end
      ST_SEL_SCAN: begin
        if (!status_i.scan_done) begin
          cmd_o.op = OP_SCAN;
        end else if (status_i.found) begin
          cmd_o.op    = OP_FINISH;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          cmd_o.op = OP_SEL_NEXT;
          state_d  = ST_SEL_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/ssa_checker.sv =====
// Port-level checks on the aggregator's results, bound to the top level.
`default_nettype none
module ssa_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_i,
  input wire logic [1:0]         status_i,
  input wire logic signed [15:0] minimum_i,
  input wire logic signed [15:0] maximum_i,
  input wire logic signed [23:0] mean_q8_i,
  input wire logic signed [15:0] median_i,
  input wire logic [6:0]         sample_total_i
);
  import ssa_pkg::*;

  // Statistics are ordered: minimum, median and maximum.
  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STS_VALID |-> minimum_i <= maximum_i)
    else $error("minimum above maximum");

  a_median_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STS_VALID |-> median_i >= minimum_i && median_i <= maximum_i)
    else $error("median outside range");

  // The mean lies between the extremes, in Q8 units.
  a_mean_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STS_VALID |->
      mean_q8_i >= (24'(minimum_i) <<< 8) && mean_q8_i <= (24'(maximum_i) <<< 8))
    else $error("mean outside range");

  // An empty aggregate reports zero total, extremes and mean.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STS_EMPTY |->
      sample_total_i == '0 && minimum_i == '0 && maximum_i == '0 && mean_q8_i == '0)
    else $error("empty result carries data");

endmodule

bind sample_statistics_aggregator ssa_checker u_ssa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (stats_o.valid),
  .status_i       (stats_o.status),
  .minimum_i      (stats_o.minimum),
  .maximum_i      (stats_o.maximum),
  .mean_q8_i      (stats_o.mean_q8),
  .median_i       (stats_o.median),
  .sample_total_i (stats_o.sample_total)
);
`default_nettype wire
